### design/box_filter_mipmap_generator_defines.svh
// Assertion macros shared by the checker of the mipmap generator.
`ifndef BOX_FILTER_MIPMAP_GENERATOR_DEFINES_SVH
`define BOX_FILTER_MIPMAP_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BFMG_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFMG_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define BFMG_ASSERT_ALWAYS(lbl, clk, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

### design/bfmg_pkg.sv
// Constants and types of the box filter mipmap generator.
package bfmg_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_LEVELS = 8;

  localparam int COORD_W = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 9;
  localparam int LEVEL_W = 4;
  localparam int CHAN_W  = 3;
  localparam int POS_W   = 7;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = PIX_W + 2 * MAX_LEVELS;
  localparam int RAM_DEPTH = MAX_WIDTH / 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;

  localparam logic [CHAN_W-1:0] CHANNELS_RGBA = 3'd4;

  typedef struct packed {
    logic               hit;
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PIX_W-1:0]   r;
    logic [PIX_W-1:0]   g;
    logic [PIX_W-1:0]   b;
    logic [PIX_W-1:0]   a;
  } lane_result_t;

endpackage

### design/bfmg_if.sv
// Pixel and mip result channel interfaces.
interface bfmg_pixel_if;
  import bfmg_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface bfmg_mip_if;
  import bfmg_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [POS_W-1:0]   out_x;
  logic [POS_W-1:0]   out_y;
  logic [PIX_W-1:0]   mean_red;
  logic [PIX_W-1:0]   mean_green;
  logic [PIX_W-1:0]   mean_blue;
  logic [PIX_W-1:0]   mean_alpha;
  logic               last;
  modport source (output valid, level, out_x, out_y, mean_red, mean_green, mean_blue,
                  mean_alpha, last, input ready);
  modport sink (input valid, level, out_x, out_y, mean_red, mean_green, mean_blue,
                mean_alpha, last, output ready);
endinterface

### design/bfmg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### design/bfmg_lane.sv
// One mip level: row-segment accumulation plus a block-column sum memory.
module bfmg_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bfmg_pkg::LEVEL_W-1:0]   lvl,
  input  logic                           en,
  input  logic                           accept,
  input  logic [bfmg_pkg::COORD_W-1:0]   col,
  input  logic [bfmg_pkg::ROW_W-1:0]     row,
  input  logic [bfmg_pkg::SIZE_W-1:0]    width,
  input  logic [bfmg_pkg::SIZE_W-1:0]    height,
  input  logic [4*bfmg_pkg::PIX_W-1:0]   pix,
  output bfmg_pkg::lane_result_t         res
);
  import bfmg_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);

  logic [COORD_W-1:0] cmask;
  logic [ROW_W-1:0]   rmask;
  logic [COORD_W-1:0] bx;
  logic [ROW_W-1:0]   by;
  logic               active;
  logic               seg_start;
  logic               seg_end;
  logic               row_first;
  logic               row_last;
  logic [4*SUM_W-1:0] partial;
  logic [4*SUM_W-1:0] partial_next;
  logic [4*SUM_W-1:0] total;
  logic [4*SUM_W-1:0] rdata;
  logic [PIX_W-1:0]   mean [4];

  assign cmask     = (COORD_W'(1) << lvl) - COORD_W'(1);
  assign rmask     = (ROW_W'(1) << lvl) - ROW_W'(1);
  assign bx        = col >> lvl;
  assign by        = row >> lvl;
  assign active    = en && ({1'b0, bx} < (width >> lvl)) && ({1'b0, by} < (height >> lvl));
  assign seg_start = (col & cmask) == '0;
  assign seg_end   = (col & cmask) == cmask;
  assign row_first = (row & rmask) == '0;
  assign row_last  = (row & rmask) == rmask;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      partial_next[c*SUM_W +: SUM_W] = (seg_start ? SUM_W'(0) : partial[c*SUM_W +: SUM_W])
                                       + SUM_W'(pix[c*PIX_W +: PIX_W]);
      total[c*SUM_W +: SUM_W] = (row_first ? SUM_W'(0) : rdata[c*SUM_W +: SUM_W])
                                + partial_next[c*SUM_W +: SUM_W];
      mean[c] = PIX_W'(total[c*SUM_W +: SUM_W] >> {lvl, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
    end else if (accept && active) begin
      partial <= partial_next;
    end
  end

  bfmg_ram #(.WIDTH(4*SUM_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (accept && active && seg_end),
    .waddr (bx[AW-1:0]),
    .wdata (total),
    .re    (accept && active && seg_start),
    .raddr (bx[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    res.hit   = active && seg_end && row_last;
    res.level = lvl;
    res.x     = POS_W'(bx);
    res.y     = POS_W'(by);
    res.r     = mean[0];
    res.g     = mean[1];
    res.b     = mean[2];
    res.a     = mean[3];
  end
endmodule

### design/bfmg_merge.sv
// Result bank that serialises the lane results of one pixel in level order.
module bfmg_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  bfmg_pkg::lane_result_t res [bfmg_pkg::MAX_LEVELS],
  output logic                   in_ready,
  bfmg_mip_if.source             mip
);
  import bfmg_pkg::*;

  lane_result_t          bank [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] pending;
  logic [MAX_LEVELS-1:0] pending_next;
  logic [MAX_LEVELS-1:0] low;
  logic [MAX_LEVELS-1:0] rest;
  lane_result_t          sel;
  logic                  found;

  always_comb begin
    low   = '0;
    sel   = bank[0];
    found = 1'b0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (pending[k] && !found) begin
        low[k] = 1'b1;
        sel    = bank[k];
        found  = 1'b1;
      end
    end
  end

  assign rest     = pending & ~low;
  assign in_ready = (pending == '0) || (rest == '0 && mip.ready);

  always_comb begin
    pending_next = pending;
    if (accept) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        pending_next[k] = res[k].hit;
      end
    end else if (mip.valid && mip.ready) begin
      pending_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        bank[k] <= res[k];
      end
    end
  end

  assign mip.valid      = pending != '0;
  assign mip.level      = sel.level;
  assign mip.out_x      = sel.x;
  assign mip.out_y      = sel.y;
  assign mip.mean_red   = sel.r;
  assign mip.mean_green = sel.g;
  assign mip.mean_blue  = sel.b;
  assign mip.mean_alpha = sel.a;
  assign mip.last       = rest == '0;
endmodule

### design/box_filter_mipmap_generator.sv
// Box filter mipmap generator: one lane per mip level and a merging result bank.
// The block takes one source pixel per cycle in raster order unless stalled.
// Each level has its own lane, which sums a row segment of a block in a register
// and keeps the partial block sums of the row band in its own memory, so all
// levels update in parallel in the cycle the pixel is accepted. A pixel that
// completes k blocks yields k words in rising level order, one per cycle from
// the result bank while mip.ready is high; the next pixel is taken in the cycle
// the last leaves, so a pixel closing more than one block stalls the input.
// A result appears in the cycle after its completing pixel is accepted.
module box_filter_mipmap_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfmg_pkg::CFG_DATA_W-1:0]  cfg_data,
  bfmg_pixel_if.sink                       pix,
  bfmg_mip_if.source                       mip
);
  import bfmg_pkg::*;

  logic [SIZE_W-1:0]  image_width;
  logic [SIZE_W-1:0]  image_height;
  logic [LEVEL_W-1:0] level_count;
  logic [CHAN_W-1:0]  channel_count;
  logic [COORD_W-1:0] col;
  logic [ROW_W-1:0]   row;
  logic [SIZE_W-1:0]  w_eff;
  logic [SIZE_W-1:0]  h_eff;
  logic [LEVEL_W-1:0] levels;
  logic [4*PIX_W-1:0] pix_word;
  logic               accept;
  logic               in_ready;
  lane_result_t       res [MAX_LEVELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= SIZE_W'(MAX_WIDTH);
      image_height  <= SIZE_W'(MAX_HEIGHT);
      level_count   <= LEVEL_W'(MAX_LEVELS);
      channel_count <= CHANNELS_RGBA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_LEVEL_COUNT:   level_count   <= cfg_data[LEVEL_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) w_eff = SIZE_W'(1);
    else if (image_width > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    else w_eff = image_width;
    if (image_height == '0) h_eff = SIZE_W'(1);
    else if (image_height > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else h_eff = image_height;
    levels = (level_count > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : level_count;
  end

  assign pix_word = {(channel_count == CHANNELS_RGBA) ? pix.alpha : PIX_W'(0),
                     pix.blue, pix.green, pix.red};
  assign accept    = pix.valid && in_ready;
  assign pix.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if ({1'b0, col} + SIZE_W'(1) >= w_eff) begin
        col <= '0;
        row <= ({1'b0, row} + SIZE_W'(1) >= h_eff) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COORD_W'(1);
      end
    end
  end

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_lane
    bfmg_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .lvl    (LEVEL_W'(i + 1)),
      .en     (LEVEL_W'(i + 1) <= levels),
      .accept (accept),
      .col    (col),
      .row    (row),
      .width  (w_eff),
      .height (h_eff),
      .pix    (pix_word),
      .res    (res[i])
    );
  end

  bfmg_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .in_ready (in_ready),
    .mip      (mip)
  );
endmodule

### design/bfmg_checker.sv
// Port-level checker for the mipmap generator and its bind.
`include "box_filter_mipmap_generator_defines.svh"

module bfmg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bfmg_pkg::LEVEL_W-1:0]  out_level,
  input logic                          out_last
);
  import bfmg_pkg::*;

  `BFMG_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !out_valid, "Result word shown after reset.")
  `BFMG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_last), "Stalled result word changed.")
  `BFMG_ASSERT_NXT(a_burst_cont, clk, rst, out_valid && out_ready && !out_last, out_valid && out_level > $past(out_level), "Result burst broken or out of level order.")
  `BFMG_ASSERT_IMP(a_no_take, clk, rst, out_valid && !out_last, !in_ready, "Pixel taken while results of a pixel remain.")
endmodule

bind box_filter_mipmap_generator bfmg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix.ready),
  .out_valid (mip.valid),
  .out_ready (mip.ready),
  .out_level (mip.level),
  .out_last  (mip.last)
);

### tb/tb_box_filter_mipmap_generator.sv
// Self-checking testbench of the box filter mipmap generator: directed table, then random images.
`timescale 1ns / 1ps

module tb_box_filter_mipmap_generator;
  import bfmg_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 12;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   out_x;
    logic [POS_W-1:0]   out_y;
    logic [PIX_W-1:0]   mean_red;
    logic [PIX_W-1:0]   mean_green;
    logic [PIX_W-1:0]   mean_blue;
    logic [PIX_W-1:0]   mean_alpha;
    logic               last;
  } mip_word_t;

  typedef struct {
    logic [CHAN_W-1:0] chan;
    logic [PIX_W-1:0]  r, g, b, a;
    bit                typed;
    mip_word_t         want;
  } pixel_row_t;

  typedef struct {
    int unsigned width, height, levels, chan, images;
  } image_phase_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfmg_pixel_if pix_if ();
  bfmg_mip_if   mip_if ();

  box_filter_mipmap_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_if),
    .mip       (mip_if)
  );

  logic [SIZE_W-1:0]  img_width_reg;
  logic [SIZE_W-1:0]  img_height_reg;
  logic [LEVEL_W-1:0] level_count_reg;
  logic [CHAN_W-1:0]  channel_count_reg;
  int unsigned next_col, next_row;
  int unsigned sum_red[1:MAX_LEVELS][0:MAX_WIDTH/2-1];
  int unsigned sum_green[1:MAX_LEVELS][0:MAX_WIDTH/2-1];
  int unsigned sum_blue[1:MAX_LEVELS][0:MAX_WIDTH/2-1];
  int unsigned sum_alpha[1:MAX_LEVELS][0:MAX_WIDTH/2-1];

  mip_word_t awaited_means[$];
  mip_word_t step_words[$];
  int        error_count;
  int        cycle_count;
  bit        no_idle;
  bit        start_hold;
  int        hold_left;

  pixel_row_t   pixel_table[16];
  image_phase_t phases[7];

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = 1'b1;
      #10 clk = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("box_filter_mipmap_generator regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void predict_mip_words(input logic [PIX_W-1:0] r, g, b, a_in);
    int unsigned w, h, lv, mask, bx, by, shift;
    bit rgba;
    logic [PIX_W-1:0] a;
    mip_word_t word;
    w = (img_width_reg == 0) ? 1 : (img_width_reg > MAX_WIDTH) ? MAX_WIDTH : img_width_reg;
    h = (img_height_reg == 0) ? 1 : (img_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : img_height_reg;
    lv = (level_count_reg > MAX_LEVELS) ? MAX_LEVELS : level_count_reg;
    rgba = (channel_count_reg == CHANNELS_RGBA);
    a = rgba ? a_in : '0;
    step_words.delete();
    for (int i = 1; i <= lv; i++) begin
      mask = (1 << i) - 1;
      bx = next_col >> i;
      by = next_row >> i;
      if (bx < (w >> i) && by < (h >> i)) begin
        if ((next_col & mask) == 0 && (next_row & mask) == 0) begin
          sum_red[i][bx] = r;
          sum_green[i][bx] = g;
          sum_blue[i][bx] = b;
          sum_alpha[i][bx] = a;
        end else begin
          sum_red[i][bx] += r;
          sum_green[i][bx] += g;
          sum_blue[i][bx] += b;
          sum_alpha[i][bx] += a;
        end
        if ((next_col & mask) == mask && (next_row & mask) == mask) begin
          shift = 2 * i;
          word.level = i;
          word.out_x = bx;
          word.out_y = by;
          word.mean_red = sum_red[i][bx] >> shift;
          word.mean_green = sum_green[i][bx] >> shift;
          word.mean_blue = sum_blue[i][bx] >> shift;
          word.mean_alpha = sum_alpha[i][bx] >> shift;
          word.last = 1'b0;
          step_words.push_back(word);
        end
      end
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    if (next_col + 1 >= w) begin
      next_col = 0;
      next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
    end else begin
      next_col = next_col + 1;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH: img_width_reg = value;
      REG_IMAGE_HEIGHT: img_height_reg = value;
      REG_LEVEL_COUNT: level_count_reg = value;
      REG_CHANNEL_COUNT: channel_count_reg = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (awaited_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, h, lv, ch);
    pix_if.valid <= 1'b0;
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_LEVEL_COUNT, lv);
    write_reg(REG_CHANNEL_COUNT, ch);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_row_t row);
    if (!no_idle && $urandom_range(99) < 16) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 16) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red <= row.r;
    pix_if.green <= row.g;
    pix_if.blue <= row.b;
    pix_if.alpha <= row.a;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_mip_words(row.r, row.g, row.b, row.a);
    if (row.typed) awaited_means.push_back(row.want);
    else foreach (step_words[k]) awaited_means.push_back(step_words[k]);
  endtask

  function automatic logic [PIX_W-1:0] random_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return $urandom_range(255);
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      mip_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (start_hold) begin
      mip_if.ready <= 1'b0;
      hold_left <= HOLD_OFF;
      start_hold = 1'b0;
    end else begin
      mip_if.ready <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    mip_word_t want;
    if (!rst && mip_if.valid && mip_if.ready) begin
      if (awaited_means.size() == 0) begin
        report_mismatch("unexpected word, level", mip_if.level, 0);
      end else begin
        want = awaited_means.pop_front();
        if (mip_if.level !== want.level) report_mismatch("level", mip_if.level, want.level);
        if (mip_if.out_x !== want.out_x) report_mismatch("out_x", mip_if.out_x, want.out_x);
        if (mip_if.out_y !== want.out_y) report_mismatch("out_y", mip_if.out_y, want.out_y);
        if (mip_if.mean_red !== want.mean_red)
          report_mismatch("mean_red", mip_if.mean_red, want.mean_red);
        if (mip_if.mean_green !== want.mean_green)
          report_mismatch("mean_green", mip_if.mean_green, want.mean_green);
        if (mip_if.mean_blue !== want.mean_blue)
          report_mismatch("mean_blue", mip_if.mean_blue, want.mean_blue);
        if (mip_if.mean_alpha !== want.mean_alpha)
          report_mismatch("mean_alpha", mip_if.mean_alpha, want.mean_alpha);
        if (mip_if.last !== want.last) report_mismatch("last", mip_if.last, want.last);
      end
    end
  end

  initial begin
    pixel_row_t row;
    logic [CHAN_W-1:0] table_chan;
    int unsigned w_eff, h_eff, count;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.red = '0;
    pix_if.green = '0;
    pix_if.blue = '0;
    pix_if.alpha = '0;
    mip_if.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    start_hold = 1'b0;
    hold_left = 0;
    img_width_reg = 256;
    img_height_reg = 256;
    level_count_reg = 8;
    channel_count_reg = CHANNELS_RGBA;
    next_col = 0;
    next_row = 0;

    for (int k = 0; k < 16; k++) begin
      pixel_table[k].chan = (k < 12) ? CHANNELS_RGBA : 3'd3;
      pixel_table[k].typed = 1'b0;
      pixel_table[k].want = '{1, 0, 0, 0, 0, 0, 0, 1};
    end
    for (int k = 0; k < 4; k++) begin
      pixel_table[k].r = 8'hff; pixel_table[k].g = 8'hff;
      pixel_table[k].b = 8'hff; pixel_table[k].a = 8'hff;
      pixel_table[k+4].r = 8'h00; pixel_table[k+4].g = 8'h00;
      pixel_table[k+4].b = 8'h00; pixel_table[k+4].a = 8'h00;
      pixel_table[k+8].r = 8'h80 + k; pixel_table[k+8].g = 8'h7f - k;
      pixel_table[k+8].b = 8'h55 * k; pixel_table[k+8].a = 8'haa >> k;
      pixel_table[k+12].r = 8'h04; pixel_table[k+12].g = 8'h04;
      pixel_table[k+12].b = 8'h04; pixel_table[k+12].a = 8'hff;
    end
    pixel_table[3].typed = 1'b1;
    pixel_table[3].want = '{1, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1};
    pixel_table[7].typed = 1'b1;
    pixel_table[15].typed = 1'b1;
    pixel_table[15].want = '{1, 0, 0, 8'h04, 8'h04, 8'h04, 8'h00, 1};

    phases[0] = '{4, 4, 2, 3, 1};
    phases[1] = '{0, 3, 0, 4, 2};
    phases[2] = '{8, 8, 15, 5, 1};
    phases[3] = '{6, 5, 2, 4, 1};
    phases[4] = '{2, 2, 1, 4, 2};
    phases[5] = '{16, 8, 4, 0, 1};
    phases[6] = '{2, 0, 1, 4, 2};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    table_chan = '0;
    foreach (pixel_table[k]) begin
      if (pixel_table[k].chan != table_chan) begin
        table_chan = pixel_table[k].chan;
        configure(2, 2, 1, table_chan);
      end
      send_pixel(pixel_table[k]);
    end

    foreach (phases[p]) begin
      configure(phases[p].width, phases[p].height, phases[p].levels, phases[p].chan);
      if (p == 4) begin
        @(posedge clk);
        write_reg(3'd5, 9'h1ff);
        write_reg(3'd7, 9'h000);
        cfg_we <= 1'b0;
      end
      no_idle = (p == 5);
      w_eff = (img_width_reg == 0) ? 1 : (img_width_reg > MAX_WIDTH) ? MAX_WIDTH : img_width_reg;
      h_eff = (img_height_reg == 0) ? 1 :
              (img_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : img_height_reg;
      count = w_eff * h_eff * phases[p].images;
      for (int n = 0; n < count; n++) begin
        if (p == 2 && n == 10) start_hold = 1'b1;
        row.chan = '0;
        row.typed = 1'b0;
        row.want = '{1, 0, 0, 0, 0, 0, 0, 1};
        row.r = random_channel();
        row.g = random_channel();
        row.b = random_channel();
        row.a = random_channel();
        send_pixel(row);
      end
    end
    pix_if.valid <= 1'b0;
    no_idle = 1'b0;

    wait_idle();
    if (error_count == 0) begin
      $display("box_filter_mipmap_generator regression: pass");
    end else begin
      $display("box_filter_mipmap_generator regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/bfmg_pkg.sv
design/bfmg_if.sv
design/bfmg_ram.sv
design/bfmg_lane.sv
design/bfmg_merge.sv
design/box_filter_mipmap_generator.sv
design/bfmg_checker.sv
tb/tb_box_filter_mipmap_generator.sv
